>>> rtl/core/nwnh_pkg.sv
// Shared types and codes for the nearest-waypoint next-hop block.
// Used by nwnh_mod_unit and nearest_waypoint_next_hop; no dependencies.

package nwnh_pkg;

	// fixed field widths of the stream words
	localparam int IDX_W     = 6;
	localparam int COORD_F_W = 10;
	localparam int RND_W     = 15;
	localparam int CNT_W     = 7;
	localparam int OP_W      = 2;
	localparam int STAT_W    = 2;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 32;

	// operation codes carried in tuser of the input word
	localparam logic [OP_W-1:0] OP_LOAD_POINT = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_LINK  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY      = 2'd2;

	// result status codes carried in tuser of the output word
	localparam logic [STAT_W-1:0] ST_NEAREST  = 2'd0;
	localparam logic [STAT_W-1:0] ST_NEIGHBOR = 2'd1;
	localparam logic [STAT_W-1:0] ST_ISOLATED = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LINK_WR,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_LINKS,
		S_CNT1,
		S_CNT2,
		S_MOD,
		S_WALK,
		S_NBR_RD,
		S_RESULT
	} nwnh_state_t;

endpackage

>>> rtl/core/nwnh_mod_unit.sv
// Restoring remainder unit: one dividend bit per cycle, all RND_W bits per start.
// Depends on nwnh_pkg for the dividend width.

module nwnh_mod_unit #(
	parameter int DIV_W = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [nwnh_pkg::RND_W-1:0] dividend,
	input  logic [DIV_W-1:0]          divisor,
	output logic                      done,
	output logic [DIV_W-1:0]          remainder
);
	import nwnh_pkg::*;

	localparam int STEP_W = $clog2(RND_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [STEP_W-1:0] step_q;
	logic [RND_W-1:0] dvd_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W-1:0] rem_d;

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[RND_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_d = DIV_W'(trial - {1'b0, div_q});
		end else begin
			rem_d = DIV_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(RND_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

>>> rtl/core/nearest_waypoint_next_hop.sv
// Nearest-waypoint search with neighbor pick, top level.
// Depends on nwnh_pkg and nwnh_mod_unit.
//
// channel  dir  handshake          content
// s_*      in   s_tvalid/s_tready  op in tuser; load or query fields in tdata
// m_*      out  m_tvalid/m_tready  status in tuser; target index and coords in tdata
// cfg_*    in   cfg_we             point_count write, no read-back
//
// Load waypoint: written when accepted. Load link bit: row read, then merged write.
// Query: the result word comes from one pass of the single distance unit over the
// active waypoints in the waypoint memory. On a waypoint, the link row is counted
// (popcount), a 15-step remainder picks a neighbor and the walk checks one column
// per cycle; a row without neighbors gives the isolated status.
// The result sits in an output register; a new word is taken while it waits.
// Reset clears the adjacency row valid bits; the waypoint memory is not cleared.

module nearest_waypoint_next_hop #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// row_index[5:0] col_index[11:6] link_bit[12] pos_x[22:13] pos_y[32:23]
	// random_value[47:33]
	input  logic [nwnh_pkg::IN_DATA_W-1:0] s_tdata,
	// op[1:0]
	input  logic [nwnh_pkg::OP_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// target_index[5:0] target_x[15:6] target_y[25:16], zero above
	output logic [nwnh_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [nwnh_pkg::STAT_W-1:0]    m_tuser,
	input  logic                           cfg_we,
	input  logic [nwnh_pkg::CNT_W-1:0]     cfg_wdata
);
	import nwnh_pkg::*;

	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NW = $clog2(MAX_POINTS + 1);
	localparam int CW = COORD_BITS;
	localparam int XB = (CW < COORD_F_W) ? CW : COORD_F_W;
	localparam int DW = 2 * CW + 1;
	localparam int NG = (MAX_POINTS + 7) / 8;
	localparam logic [IDX_W:0] MAX_LIM = (IDX_W + 1)'(MAX_POINTS);

	// input word fields
	logic [IDX_W-1:0]     in_row;
	logic [IDX_W-1:0]     in_col;
	logic                 in_link;
	logic [COORD_F_W-1:0] in_x;
	logic [COORD_F_W-1:0] in_y;
	logic [RND_W-1:0]     in_rnd;
	logic [CW-1:0]        in_cx;
	logic [CW-1:0]        in_cy;
	logic                 row_ok;
	logic                 col_ok;
	logic                 s_accept;

	assign in_row  = s_tdata[5:0];
	assign in_col  = s_tdata[11:6];
	assign in_link = s_tdata[12];
	assign in_x    = s_tdata[22:13];
	assign in_y    = s_tdata[32:23];
	assign in_rnd  = s_tdata[47:33];
	assign in_cx   = CW'(in_x[XB-1:0]);
	assign in_cy   = CW'(in_y[XB-1:0]);
	assign row_ok  = {1'b0, in_row} < MAX_LIM;
	assign col_ok  = {1'b0, in_col} < MAX_LIM;
	assign s_accept = s_tvalid && s_tready;

	// configuration and active count
	logic [CNT_W-1:0]      point_count_q;
	logic [NW-1:0]         cnt_eff;
	logic [IW-1:0]         last_idx;
	logic [MAX_POINTS-1:0] col_mask;

	always_comb begin
		if (point_count_q == '0) begin
			cnt_eff = NW'(1);
		end else if (point_count_q > CNT_W'(MAX_POINTS)) begin
			cnt_eff = NW'(MAX_POINTS);
		end else begin
			cnt_eff = NW'(point_count_q);
		end
		last_idx = IW'(cnt_eff - 1'b1);
		for (int j = 0; j < MAX_POINTS; j++) begin
			col_mask[j] = NW'(j) < cnt_eff;
		end
	end

	// memories
	logic [2*CW-1:0]       wp_mem [MAX_POINTS];
	logic [2*CW-1:0]       wp_rd_q;
	logic                  wp_we;
	logic [IW-1:0]         wp_raddr;
	logic [CW-1:0]         rd_x;
	logic [CW-1:0]         rd_y;

	logic [MAX_POINTS-1:0] adj_mem [MAX_POINTS];
	logic [MAX_POINTS-1:0] adj_rd_q;
	logic [MAX_POINTS-1:0] adj_valid_q;
	logic                  adj_we;
	logic [IW-1:0]         adj_raddr;
	logic [MAX_POINTS-1:0] adj_wdata;

	assign rd_x = wp_rd_q[CW-1:0];
	assign rd_y = wp_rd_q[2*CW-1:CW];

	always_ff @(posedge clk) begin
		if (wp_we) begin
			wp_mem[in_row[IW-1:0]] <= {in_cy, in_cx};
		end
		wp_rd_q <= wp_mem[wp_raddr];
	end

	// query and load registers
	logic [IW-1:0]    q_row_q;
	logic [IW-1:0]    q_col_q;
	logic             q_link_q;
	logic [CW-1:0]    q_x_q;
	logic [CW-1:0]    q_y_q;
	logic [RND_W-1:0] q_rnd_q;

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[q_row_q] <= adj_wdata;
		end
		adj_rd_q <= adj_mem[adj_raddr];
	end

	// merge one bit into the stored row; an unwritten row reads as zero
	always_comb begin
		adj_wdata = adj_valid_q[q_row_q] ? adj_rd_q : '0;
		adj_wdata[q_col_q] = q_link_q;
	end

	// distance pipeline
	nwnh_state_t   state_q;
	nwnh_state_t   state_d;
	logic [IW-1:0] scan_q;
	logic          v_s1, v_s2;
	logic          last_s1, last_s2;
	logic [IW-1:0] idx_s1, idx_s2;
	logic [2*CW-1:0] sqx_s2, sqy_s2;
	logic [CW-1:0] x_s2, y_s2;
	logic [CW-1:0] dx, dy;
	logic [2*CW-1:0] sqx, sqy;
	logic [DW-1:0] dist_sum;
	logic          take_best;
	logic [DW-1:0] best_d_q;
	logic [IW-1:0] best_idx_q;
	logic [CW-1:0] best_x_q;
	logic [CW-1:0] best_y_q;

	assign dx   = (rd_x > q_x_q) ? rd_x - q_x_q : q_x_q - rd_x;
	assign dy   = (rd_y > q_y_q) ? rd_y - q_y_q : q_y_q - rd_y;
	assign sqx  = dx * dx;
	assign sqy  = dy * dy;
	assign dist_sum = DW'(sqx_s2) + DW'(sqy_s2);
	// strict less keeps the lowest index on a tie
	assign take_best = v_s2 && ((idx_s2 == '0) || (dist_sum < best_d_q));

	// neighbor selection
	logic [MAX_POINTS-1:0] links_q;
	logic [NG*8-1:0]       links_pad;
	logic [3:0]            grp_d [NG];
	logic [3:0]            grp_q [NG];
	logic [NW-1:0]         deg_sum;
	logic [NW-1:0]         pick_q;
	logic [IW-1:0]         walk_idx_q;
	logic                  mod_start;
	logic                  mod_done;
	logic [NW-1:0]         mod_rem;
	logic                  walk_hit;

	assign links_pad = (NG * 8)'(links_q);
	assign walk_hit  = links_q[0] && (pick_q == '0);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int b = 0; b < 8; b++) begin
				grp_d[g] = grp_d[g] + 4'(links_pad[g*8+b]);
			end
		end
		deg_sum = '0;
		for (int g = 0; g < NG; g++) begin
			deg_sum = deg_sum + NW'(grp_q[g]);
		end
	end

	nwnh_mod_unit #(
		.DIV_W(NW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (q_rnd_q),
		.divisor  (deg_sum),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	// result staging and output register
	logic              res_load;
	logic [STAT_W-1:0] res_status_d;
	logic [IW-1:0]     res_idx_d;
	logic [CW-1:0]     res_x_d, res_y_d;
	logic [STAT_W-1:0] res_status_q;
	logic [IW-1:0]     res_idx_q;
	logic [CW-1:0]     res_x_q, res_y_q;
	logic              out_load;
	logic              m_tvalid_q;
	logic [STAT_W-1:0] m_status_q;
	logic [IW-1:0]     m_idx_q;
	logic [CW-1:0]     m_x_q, m_y_q;

	assign out_load = (state_q == S_RESULT) && (!m_tvalid_q || m_tready);
	assign s_tready = (state_q == S_IDLE);

	// sequencer
	always_comb begin
		state_d      = state_q;
		wp_we        = 1'b0;
		adj_we       = 1'b0;
		wp_raddr     = scan_q;
		adj_raddr    = best_idx_q;
		mod_start    = 1'b0;
		res_load     = 1'b0;
		res_status_d = ST_NEAREST;
		res_idx_d    = best_idx_q;
		res_x_d      = best_x_q;
		res_y_d      = best_y_q;
		unique case (state_q)
			S_IDLE: begin
				adj_raddr = in_row[IW-1:0];
				if (s_accept) begin
					case (s_tuser)
						OP_LOAD_POINT: wp_we = row_ok;
						OP_LOAD_LINK: begin
							if (row_ok && col_ok) begin
								state_d = S_LINK_WR;
							end
						end
						OP_QUERY: state_d = S_SCAN;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_LINK_WR: begin
				adj_we  = 1'b1;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				if (scan_q == last_idx) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (v_s2 && last_s2) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (best_d_q != '0) begin
					res_load = 1'b1;
					state_d  = S_RESULT;
				end else begin
					state_d = S_LINKS;
				end
			end
			S_LINKS: state_d = S_CNT1;
			S_CNT1: state_d = S_CNT2;
			S_CNT2: begin
				if (deg_sum == '0) begin
					res_load     = 1'b1;
					res_status_d = ST_ISOLATED;
					res_idx_d    = '0;
					res_x_d      = '0;
					res_y_d      = '0;
					state_d      = S_RESULT;
				end else begin
					mod_start = 1'b1;
					state_d   = S_MOD;
				end
			end
			S_MOD: begin
				if (mod_done) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				wp_raddr = walk_idx_q;
				if (walk_hit) begin
					state_d = S_NBR_RD;
				end
			end
			S_NBR_RD: begin
				res_load     = 1'b1;
				res_status_d = ST_NEIGHBOR;
				res_idx_d    = walk_idx_q;
				res_x_d      = rd_x;
				res_y_d      = rd_y;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			point_count_q <= CNT_W'(1);
			adj_valid_q   <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				point_count_q <= cfg_wdata;
			end
			if (adj_we) begin
				adj_valid_q[q_row_q] <= 1'b1;
			end
			v_s1 <= (state_q == S_SCAN);
			v_s2 <= v_s1;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			q_row_q  <= in_row[IW-1:0];
			q_col_q  <= in_col[IW-1:0];
			q_link_q <= in_link;
			q_x_q    <= in_cx;
			q_y_q    <= in_cy;
			q_rnd_q  <= in_rnd;
			scan_q   <= '0;
		end else if (state_q == S_SCAN) begin
			scan_q <= scan_q + 1'b1;
		end

		// distance unit stages
		idx_s1  <= scan_q;
		last_s1 <= (scan_q == last_idx);
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		sqx_s2  <= sqx;
		sqy_s2  <= sqy;
		x_s2    <= rd_x;
		y_s2    <= rd_y;
		if (take_best) begin
			best_d_q   <= dist_sum;
			best_idx_q <= idx_s2;
			best_x_q   <= x_s2;
			best_y_q   <= y_s2;
		end

		if (state_q == S_LINKS) begin
			links_q <= (adj_valid_q[best_idx_q] ? adj_rd_q : '0) & col_mask;
		end
		if (state_q == S_CNT1) begin
			grp_q <= grp_d;
		end
		if (mod_done) begin
			pick_q     <= mod_rem;
			walk_idx_q <= '0;
		end else if ((state_q == S_WALK) && !walk_hit) begin
			// advance to the next column, count down on each neighbor passed
			links_q    <= links_q >> 1;
			walk_idx_q <= walk_idx_q + 1'b1;
			if (links_q[0]) begin
				pick_q <= pick_q - 1'b1;
			end
		end

		if (res_load) begin
			res_status_q <= res_status_d;
			res_idx_q    <= res_idx_d;
			res_x_q      <= res_x_d;
			res_y_q      <= res_y_d;
		end
		if (out_load) begin
			m_status_q <= res_status_q;
			m_idx_q    <= res_idx_q;
			m_x_q      <= res_x_q;
			m_y_q      <= res_y_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {6'b0, COORD_F_W'(m_y_q), COORD_F_W'(m_x_q), IDX_W'(m_idx_q)};

endmodule

>>> sim/tb.sv
// Self-checking bench for nearest_waypoint_next_hop: loads, queries, neighbor picks.
// Depends on nwnh_pkg and the block's RTL; predicts every result in step with
// the accepted input words.

module tb;
	import nwnh_pkg::*;

	localparam int POINTS         = 64;
	localparam int SETTLE_CYCLES  = 200;
	localparam int LONG_HOLD      = 600;
	localparam int WATCHDOG_LIMIT = 5000;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// idle mixes and phase extras
	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;
	localparam int PH_PLAIN      = 0;
	localparam int PH_LONG_HOLD  = 1;
	localparam int PH_SEND_PAUSE = 2;

	typedef struct {
		logic [OP_W-1:0]      op;
		logic [IDX_W-1:0]     row;
		logic [IDX_W-1:0]     col;
		logic                 link;
		logic [COORD_F_W-1:0] px;
		logic [COORD_F_W-1:0] py;
		logic [RND_W-1:0]     rnd;
	} word_t;

	typedef struct {
		logic [STAT_W-1:0]    status;
		logic [IDX_W-1:0]     index;
		logic [COORD_F_W-1:0] x;
		logic [COORD_F_W-1:0] y;
	} hop_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CNT_W-1:0]      cfg_wdata = '0;

	// stimulus control, written by the sequence with nonblocking assignments
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	logic send_hold = 1'b0;
	logic hold_armed = 1'b0;

	word_t pending[$];
	hop_t  hop_expected[$];
	int    err_count = 0;
	int    quiet_cycles = 0;
	int    hold_cycles = 0;

	// predictor state, advanced on accepted words and point count writes
	logic [CNT_W-1:0]     point_count_cfg = 7'd1;
	logic [COORD_F_W-1:0] way_x [POINTS];
	logic [COORD_F_W-1:0] way_y [POINTS];
	logic [POINTS-1:0]    link_rows [POINTS];

	// generator's view of the table at the time a word is queued
	logic [COORD_F_W-1:0] gen_x [POINTS];
	logic [COORD_F_W-1:0] gen_y [POINTS];
	logic [POINTS-1:0]    gen_written = '0;

	nearest_waypoint_next_hop u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic int active_points(input logic [CNT_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > POINTS)
			return POINTS;
		return int'(c);
	endfunction

	task automatic report_error(input string msg);
		err_count++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// apply one accepted word to the table and queue the hop it yields
	task automatic predict_next_hop(input word_t w);
		int   n;
		int   best;
		int   best_dist;
		int   sq_len;
		int   dx;
		int   dy;
		int   degree;
		int   pick;
		int   seen;
		int   j;
		logic [POINTS-1:0] links;
		hop_t h;
		case (w.op)
			OP_LOAD_POINT: begin
				way_x[w.row] = w.px;
				way_y[w.row] = w.py;
			end
			OP_LOAD_LINK: begin
				link_rows[w.row][w.col] = w.link;
			end
			OP_QUERY: begin
				n = active_points(point_count_cfg);
				best = 0;
				best_dist = 32'h7fffffff;
				for (int i = 0; i < n; i++) begin
					dx = int'(w.px) - int'(way_x[i]);
					dy = int'(w.py) - int'(way_y[i]);
					sq_len = dx * dx + dy * dy;
					// strict compare keeps the lowest index on a tie
					if (sq_len < best_dist) begin
						best_dist = sq_len;
						best = i;
					end
				end
				if (best_dist != 0) begin
					h = '{ST_NEAREST, best[IDX_W-1:0], way_x[best], way_y[best]};
				end else begin
					links = link_rows[best];
					degree = 0;
					for (j = 0; j < n; j++)
						if (links[j])
							degree++;
					if (degree == 0) begin
						h = '{ST_ISOLATED, '0, '0, '0};
					end else begin
						pick = int'(w.rnd) % degree;
						seen = 0;
						for (j = 0; j < n; j++) begin
							if (links[j]) begin
								if (seen == pick)
									break;
								seen++;
							end
						end
						h = '{ST_NEIGHBOR, j[IDX_W-1:0], way_x[j], way_y[j]};
					end
				end
				hop_expected.insert(hop_expected.size(), h);
			end
			default: ;
		endcase
	endtask

	// sender: the word at the head of pending is the one on the bus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_next_hop(pending.pop_front());
			if (s_tvalid && !s_tready) begin
				// hold the offered word
			end else if (pending.size() != 0 && !send_hold &&
					$urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {pending[0].rnd, pending[0].py, pending[0].px,
					pending[0].link, pending[0].col, pending[0].row};
				s_tuser  <= pending[0].op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: compare each hop, then pick the next ready
	always @(posedge clk or negedge arst_n) begin : rx_side
		hop_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cycles <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (hop_expected.size() == 0) begin
					report_error($sformatf("result with none pending, status %0d index %0d",
						m_tuser, m_tdata[5:0]));
				end else begin
					want = hop_expected.pop_front();
					if (m_tuser !== want.status)
						report_error($sformatf("status got %0d want %0d",
							m_tuser, want.status));
					if (m_tdata[5:0] !== want.index)
						report_error($sformatf("index got %0d want %0d",
							m_tdata[5:0], want.index));
					if (m_tdata[15:6] !== want.x)
						report_error($sformatf("x got %0d want %0d", m_tdata[15:6], want.x));
					if (m_tdata[25:16] !== want.y)
						report_error($sformatf("y got %0d want %0d",
							m_tdata[25:16], want.y));
					if (m_tdata[31:26] !== '0)
						report_error($sformatf("pad bits got %h", m_tdata[31:26]));
				end
			end
			if (hold_armed && hold_cycles < LONG_HOLD) begin
				hold_cycles <= hold_cycles + 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic void push_word(input logic [OP_W-1:0] op, input int row, input int col,
			input int link, input int px, input int py, input int rnd);
		word_t w;
		w.op   = op;
		w.row  = row[IDX_W-1:0];
		w.col  = col[IDX_W-1:0];
		w.link = link[0];
		w.px   = px[COORD_F_W-1:0];
		w.py   = py[COORD_F_W-1:0];
		w.rnd  = rnd[RND_W-1:0];
		if (op == OP_LOAD_POINT) begin
			gen_x[w.row] = w.px;
			gen_y[w.row] = w.py;
			gen_written[w.row] = 1'b1;
		end
		pending.insert(pending.size(), w);
	endfunction

	// favor a few low indices so their rows gather links
	function automatic int pick_index(input int n);
		if ($urandom_range(99) < 60)
			return $urandom_range((n < 8 ? n : 8) - 1);
		return $urandom_range(n - 1);
	endfunction

	function automatic int clamp_coord(input int v);
		if (v < 0)
			return 0;
		if (v > 1023)
			return 1023;
		return v;
	endfunction

	// queue one random word; returns 0 for a word the block ignores
	function automatic bit push_random_word(input int n);
		int r;
		int i;
		int k;
		int px;
		int py;
		int rnd;
		r = $urandom_range(99);
		rnd = $urandom_range(32767);
		if ($urandom_range(9) == 0)
			rnd = $urandom_range(1) ? 32767 : 0;
		if (r < 3) begin
			push_word(OP_UNUSED, $urandom_range(63), $urandom_range(63), $urandom_range(1),
				$urandom_range(1023), $urandom_range(1023), rnd);
			return 1'b0;
		end
		if (r < 13) begin
			i = $urandom_range(1) ? pick_index(n) : $urandom_range(63);
			r = $urandom_range(99);
			if (r < 20) begin
				// duplicate another waypoint to force ties
				k = pick_index(n);
				px = gen_x[k];
				py = gen_y[k];
			end else if (r < 30) begin
				px = $urandom_range(1) ? 1023 : 0;
				py = $urandom_range(1) ? 1023 : 0;
			end else begin
				px = $urandom_range(1023);
				py = $urandom_range(1023);
			end
			push_word(OP_LOAD_POINT, i, $urandom_range(63), $urandom_range(1), px, py, rnd);
			return 1'b1;
		end
		if (r < 38) begin
			push_word(OP_LOAD_LINK,
				$urandom_range(99) < 80 ? pick_index(n) : $urandom_range(63),
				$urandom_range(99) < 75 ? $urandom_range(n - 1) : $urandom_range(63),
				$urandom_range(99) < 65, $urandom_range(1023), $urandom_range(1023), rnd);
			return 1'b1;
		end
		r = $urandom_range(99);
		i = pick_index(n);
		if (r < 55) begin
			px = gen_x[i];
			py = gen_y[i];
		end else if (r < 70) begin
			px = clamp_coord(int'(gen_x[i]) + $urandom_range(6) - 3);
			py = clamp_coord(int'(gen_y[i]) + $urandom_range(6) - 3);
		end else begin
			px = $urandom_range(1023);
			py = $urandom_range(1023);
		end
		push_word(OP_QUERY, $urandom_range(63), $urandom_range(63), $urandom_range(1),
			px, py, rnd);
		return 1'b1;
	endfunction

	// register writes only once the block has gone quiet
	task automatic write_point_count(input logic [CNT_W-1:0] value);
		while (pending.size() != 0 || hop_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		point_count_cfg = value;
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] count, input int words,
			input int mode, input int extra);
		int n;
		int queued;
		write_point_count(count);
		n = active_points(count);
		send_idle_pct  <= (mode == IDLE_SEND) ? 51 : (mode == IDLE_BOTH) ? 13 : 0;
		recv_stall_pct <= (mode == IDLE_RECV) ? 51 : (mode == IDLE_BOTH) ? 13 : 0;
		// every waypoint a query can touch must hold a value first
		for (int i = 0; i < n; i++)
			if (!gen_written[i])
				push_word(OP_LOAD_POINT, i, $urandom_range(63), $urandom_range(1),
					$urandom_range(1023), $urandom_range(1023), $urandom_range(32767));
		if (extra == PH_LONG_HOLD)
			hold_armed <= 1'b1;
		queued = 0;
		while (queued < words)
			queued += push_random_word(n);
		if (extra == PH_SEND_PAUSE) begin
			while (pending.size() > words / 2)
				@(posedge clk);
			send_hold <= 1'b1;
			@(posedge clk);
			while (s_tvalid || hop_expected.size() != 0)
				@(posedge clk);
			send_hold <= 1'b0;
		end
	endtask

	initial begin
		for (int i = 0; i < POINTS; i++) begin
			way_x[i] = '0;
			way_y[i] = '0;
			link_rows[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single waypoint: far miss, isolated hit, self link, link past the count
		push_word(OP_LOAD_POINT, 0, 0, 0, 1023, 1023, 0);
		push_word(OP_QUERY, 0, 0, 0, 0, 0, 0);
		push_word(OP_QUERY, 63, 63, 1, 1023, 1023, 32767);
		push_word(OP_LOAD_LINK, 0, 0, 1, 0, 0, 0);
		push_word(OP_LOAD_LINK, 0, 5, 1, 0, 0, 0);
		push_word(OP_QUERY, 0, 0, 0, 1023, 1023, 32767);
		push_word(OP_UNUSED, 63, 63, 1, 1023, 1023, 32767);
		push_word(OP_LOAD_LINK, 63, 63, 1, 1023, 1023, 32767);
		push_word(OP_LOAD_LINK, 63, 63, 0, 0, 0, 0);
		push_word(OP_LOAD_LINK, 0, 0, 0, 0, 0, 0);
		push_word(OP_QUERY, 0, 0, 0, 1023, 1023, 5);
		// a zero count still searches one waypoint
		write_point_count(7'd0);
		push_word(OP_QUERY, 0, 0, 0, 1023, 1023, 7);
		// tied pair at the origin, neighbor picks by remainder
		push_word(OP_LOAD_POINT, 1, 0, 0, 0, 0, 0);
		push_word(OP_LOAD_POINT, 2, 0, 0, 0, 0, 0);
		push_word(OP_LOAD_POINT, 3, 0, 0, 512, 512, 0);
		write_point_count(7'd4);
		push_word(OP_LOAD_LINK, 1, 0, 1, 0, 0, 0);
		push_word(OP_LOAD_LINK, 1, 2, 1, 0, 0, 0);
		push_word(OP_LOAD_LINK, 1, 3, 1, 0, 0, 0);
		push_word(OP_QUERY, 0, 0, 0, 0, 0, 0);
		push_word(OP_QUERY, 0, 0, 0, 0, 0, 1);
		push_word(OP_QUERY, 0, 0, 0, 0, 0, 2);
		push_word(OP_QUERY, 0, 0, 0, 0, 0, 32767);
		push_word(OP_QUERY, 0, 0, 0, 300, 300, 0);
		push_word(OP_QUERY, 0, 0, 0, 1, 0, 0);
		push_word(OP_QUERY, 0, 0, 0, 512, 512, 0);

		run_phase(7'd64,  250, IDLE_NONE, PH_LONG_HOLD);
		run_phase(7'd127, 230, IDLE_SEND, PH_PLAIN);
		run_phase(7'd2,   200, IDLE_RECV, PH_PLAIN);
		run_phase(7'd33,  230, IDLE_BOTH, PH_PLAIN);
		run_phase(7'd100, 230, IDLE_NONE, PH_SEND_PAUSE);
		run_phase(7'd1,   120, IDLE_SEND, PH_PLAIN);
		run_phase(7'd17,  230, IDLE_RECV, PH_PLAIN);
		run_phase(7'd64,  230, IDLE_BOTH, PH_PLAIN);

		while (pending.size() != 0 || hop_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
